FILE: rtl/core/xes_pkg.sv
// Shared types, constants and escape tables for the XML escape / UTF-8 sanitizer.
// Used by the controller, the datapath and the top level.
package xes_pkg;

    // Default depth of the pending multi-byte sequence store
    localparam int DefSeqSlots = 20;

    // Character codes used by the escape tables
    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChQuot  = 8'h22;
    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChApos  = 8'h27;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChA     = 8'h61;
    localparam logic [7:0] ChG     = 8'h67;
    localparam logic [7:0] ChL     = 8'h6C;
    localparam logic [7:0] ChM     = 8'h6D;
    localparam logic [7:0] ChO     = 8'h6F;
    localparam logic [7:0] ChP     = 8'h70;
    localparam logic [7:0] ChQ     = 8'h71;
    localparam logic [7:0] ChS     = 8'h73;
    localparam logic [7:0] ChT     = 8'h74;
    localparam logic [7:0] ChU     = 8'h75;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FLUSH_OUT,
        S_FLUSH_RD,
        S_CHARS,
        S_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture accepted item, plan its results
        logic rd_next;     // advance flush read index
        logic load_flush;  // load output register from pending store
        logic load_char;   // load output register with next escape char
        logic commit;      // update pending store and count
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic flush_none;  // no pending bytes to flush for this item
        logic flush_last;  // flush index is on the final pending byte
        logic chars_none;  // item writes no characters of its own
        logic chars_last;  // char index is on the final character
    } t_sts;

    // Number of characters an ASCII byte escapes to (0 = dropped)
    function automatic logic [2:0] esc_len(input logic [7:0] c);
        logic [2:0] len;
        unique case (c)
            ChAmp:              len = 3'd5;
            ChLt, ChGt:         len = 3'd4;
            ChQuot, ChApos:     len = 3'd6;
            ChTab, ChLf, ChCr:  len = 3'd1;
            default:            len = (c >= ChSpace && !c[7]) ? 3'd1 : 3'd0;
        endcase
        return len;
    endfunction

    // Character k of the escaped form of an ASCII byte
    function automatic logic [7:0] esc_char(input logic [7:0] c, input logic [2:0] k);
        logic [7:0] ch;
        unique case (c)
            ChAmp: begin
                unique case (k)
                    3'd0:    ch = ChAmp;
                    3'd1:    ch = ChA;
                    3'd2:    ch = ChM;
                    3'd3:    ch = ChP;
                    default: ch = ChSemi;
                endcase
            end
            ChLt: begin
                unique case (k)
                    3'd0:    ch = ChAmp;
                    3'd1:    ch = ChL;
                    3'd2:    ch = ChT;
                    default: ch = ChSemi;
                endcase
            end
            ChGt: begin
                unique case (k)
                    3'd0:    ch = ChAmp;
                    3'd1:    ch = ChG;
                    3'd2:    ch = ChT;
                    default: ch = ChSemi;
                endcase
            end
            ChQuot: begin
                unique case (k)
                    3'd0:    ch = ChAmp;
                    3'd1:    ch = ChQ;
                    3'd2:    ch = ChU;
                    3'd3:    ch = ChO;
                    3'd4:    ch = ChT;
                    default: ch = ChSemi;
                endcase
            end
            ChApos: begin
                unique case (k)
                    3'd0:    ch = ChAmp;
                    3'd1:    ch = ChA;
                    3'd2:    ch = ChP;
                    3'd3:    ch = ChO;
                    3'd4:    ch = ChS;
                    default: ch = ChSemi;
                endcase
            end
            ChTab, ChLf, ChCr: ch = ChSpace;
            default:           ch = c;
        endcase
        return ch;
    endfunction

    // Sequence width a lead byte declares (0 = unchecked, 0xFC and up)
    function automatic logic [2:0] declared_width(input logic [7:0] lead);
        logic [2:0] w;
        priority if (!lead[5]) w = 3'd2;
        else if (!lead[4])     w = 3'd3;
        else if (!lead[3])     w = 3'd4;
        else if (!lead[2])     w = 3'd5;
        else                   w = 3'd0;
        return w;
    endfunction

endpackage

FILE: rtl/core/xes_ctrl.sv
// Controller state machine of the sanitizer: sequences flush, escape and commit.
// Depends on xes_pkg for the state, command and status types.
module xes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output xes_pkg::t_cmd o_cmd,
    input  xes_pkg::t_sts i_sts
);
    import xes_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (!i_sts.flush_none) n_state = S_FLUSH_OUT;
                else if (!i_sts.chars_none)     n_state = S_CHARS;
                else                            n_state = S_COMMIT;
            end
            S_FLUSH_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_flush = 1'b1;
                    if (i_sts.flush_last) begin
                        n_state = i_sts.chars_none ? S_COMMIT : S_CHARS;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_FLUSH_RD;
                    end
                end
            end
            // wait for the registered read of the next pending byte
            S_FLUSH_RD: begin
                n_state = S_FLUSH_OUT;
            end
            S_CHARS: begin
                if (i_sts.out_free) begin
                    o_cmd.load_char = 1'b1;
                    if (i_sts.chars_last) begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/xes_datapath.sv
// Datapath of the sanitizer: item capture, pending sequence store, escape
// lookup and output register. Depends on xes_pkg for types and tables.
module xes_datapath #(
    parameter int SEQ_SLOTS = xes_pkg::DefSeqSlots
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_s_tdata,
    input  logic          i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,
    output logic          o_m_tlast,
    input  xes_pkg::t_cmd i_cmd,
    output xes_pkg::t_sts o_sts
);
    import xes_pkg::*;

    localparam int CW = $clog2(SEQ_SLOTS);
    localparam logic [CW-1:0] LastCount = CW'(SEQ_SLOTS - 1);

    // Pending sequence store
    logic [7:0]    r_mem [SEQ_SLOTS];
    logic [7:0]    r_rdata;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_lead;

    // Captured item and its plan
    logic          r_kind;
    logic [7:0]    r_byte;
    logic [CW-1:0] r_flush_n;
    logic [CW-1:0] n_flush_n;
    logic [2:0]    r_ch_n;
    logic [2:0]    n_ch_n;
    logic [CW-1:0] r_idx;
    logic [2:0]    r_ch;

    // Output register
    logic          r_m_valid;
    logic [7:0]    r_m_data;
    logic          r_m_last;

    logic          in_starter;
    logic [2:0]    lead_w;
    logic          wr_en;
    logic [CW-1:0] wr_addr;

    // Plan for the item on the input port
    always_comb begin
        in_starter = i_s_tdata[7:6] == 2'b11 || !i_s_tdata[7];
        lead_w     = declared_width(r_lead);
        n_flush_n  = '0;
        n_ch_n     = 3'd0;
        if (i_s_tuser) begin
            n_flush_n = r_count;
            n_ch_n    = 3'd1;
        end else if (in_starter) begin
            if (r_count != '0 && (lead_w == 3'd0 || 32'(lead_w) == 32'(r_count))) begin
                n_flush_n = r_count;
            end
            n_ch_n = i_s_tdata[7] ? 3'd0 : esc_len(i_s_tdata);
        end
    end

    // Store update at the end of the item
    always_comb begin
        n_count = r_count;
        wr_en   = 1'b0;
        wr_addr = r_count;
        if (r_kind) begin
            n_count = '0;
        end else if (r_byte[7:6] == 2'b11) begin
            n_count = CW'(1);
            wr_en   = 1'b1;
            wr_addr = '0;
        end else if (!r_byte[7]) begin
            n_count = '0;
        end else if (r_count != '0) begin
            if (r_count >= LastCount) begin
                n_count = '0;
            end else begin
                n_count = r_count + CW'(1);
                wr_en   = 1'b1;
            end
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            r_mem[wr_addr] <= r_byte;
        end
        r_rdata <= r_mem[r_idx];
    end

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // Copy of the lead byte for the width check
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en && wr_addr == '0) begin
            r_lead <= r_byte;
        end
    end

    // Item capture and indexes
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind    <= i_s_tuser;
            r_byte    <= i_s_tdata;
            r_flush_n <= n_flush_n;
            r_ch_n    <= n_ch_n;
            r_idx     <= '0;
            r_ch      <= 3'd0;
        end else begin
            if (i_cmd.rd_next) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.load_char) begin
                r_ch <= r_ch + 3'd1;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.out_free   = !r_m_valid || i_m_tready;
        o_sts.flush_none = r_flush_n == '0;
        o_sts.flush_last = r_idx == r_flush_n - CW'(1);
        o_sts.chars_none = r_ch_n == 3'd0;
        o_sts.chars_last = r_ch == r_ch_n - 3'd1;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_flush || i_cmd.load_char) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_flush) begin
            r_m_data <= r_rdata;
            r_m_last <= o_sts.flush_last && o_sts.chars_none;
        end else if (i_cmd.load_char) begin
            r_m_data <= r_kind ? ChNul : esc_char(r_byte, r_ch);
            r_m_last <= o_sts.chars_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule

FILE: rtl/core/xml_escape_utf8_sanitizer_top.sv
// XML escape with UTF-8 width check. One data byte or end marker per input
// transfer; escaped bytes leave on the output stream, tlast on the final byte
// of each item. After an item is taken the block is busy through a dispatch
// state, the flush of F > 0 pending bytes if any, each flushed byte going
// through the registered read port of the pending store, the C characters
// written for the byte (0 to 6) and a commit state; output stalls add to this. The
// next item is taken while the last result still sits in the output register.
// The pending store needs no clearing after reset: only entries below the
// pending count are read.
// Top level: instantiates xes_ctrl and xes_datapath; depends on xes_pkg.
module xml_escape_utf8_sanitizer_top #(
    parameter int SEQ_SLOTS = xes_pkg::DefSeqSlots
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] kind (1 = end of string)
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // run_last
);
    import xes_pkg::*;

    t_cmd cmd;
    t_sts sts;

    xes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    xes_datapath #(
        .SEQ_SLOTS (SEQ_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

FILE: rtl/core/xes_checker.sv
// Port-level checks for the sanitizer top level, attached by bind.
// Sees only the ports of xml_escape_utf8_sanitizer_top.
module xes_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // One item at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken again right after a transfer");

    // A zero byte is only ever the terminator, the final result of its item
    a_nul_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata == 8'h00 |-> o_m_tlast)
        else $error("zero byte not marked last");

    // No control byte below 0x20 other than the terminator leaves the block
    a_no_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata == 8'h00 || o_m_tdata >= 8'h20)
        else $error("control byte on output");

endmodule

bind xml_escape_utf8_sanitizer_top xes_checker u_xes_checker (.*);

FILE: dv/xml_escape_utf8_sanitizer_top_test.sv
// Self-checking testbench for xml_escape_utf8_sanitizer_top: streams text bytes and end
// markers in, predicts the escaped, UTF-8 filtered output and checks every output transfer.
// Depends on xes_pkg and the top level RTL only.
`timescale 1ns / 1ps

module xml_escape_utf8_sanitizer_top_test;
    import xes_pkg::*;

    localparam int SEQ_SLOTS = DefSeqSlots;
    localparam int RANDOM_ITEMS = 450;

    // Input item kind, carried on tuser
    typedef enum logic {K_DATA = 1'b0, K_END = 1'b1} t_item_kind;

    typedef struct packed {
        t_item_kind kind;
        logic [7:0] data;
        logic       drain;   // hold this item until all output has drained
    } t_text_item;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } t_out_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // [7:0] in_byte
    logic       i_s_tuser = 1'b0;    // [0] kind (1 = end of string)
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] out_byte
    logic       o_m_tlast;           // run_last

    t_text_item text_items[$];
    t_out_beat  expected_chars[$];

    // Predictor copy of the held multi-byte sequence
    logic [7:0] held_seq[SEQ_SLOTS];
    int         held_len = 0;

    int  mismatch_cnt = 0;
    bit  in_taken = 1'b0;
    bit  drain_next = 1'b0;
    int  send_gap = 0;
    int  sink_stall = 0;
    int  tb_cycle = 0;

    xml_escape_utf8_sanitizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Width a lead byte announces; 0 means the length is not checked
    function automatic int utf8_lead_len(input logic [7:0] lead);
        casez (lead)
            8'b110?_????: return 2;
            8'b1110_????: return 3;
            8'b1111_0???: return 4;
            8'b1111_10??: return 5;
            default:      return 0;
        endcase
    endfunction

    // Expected output of one accepted item; updates the held sequence
    task automatic predict_escaped(input t_item_kind kind, input logic [7:0] c);
        logic [7:0] chars[$];
        string      ent;
        int         w;
        ent = "";
        if (kind == K_END) begin
            // flush whatever is held, unchecked, then the terminator
            for (int i = 0; i < held_len; i++) chars.push_back(held_seq[i]);
            held_len = 0;
            chars.push_back(ChNul);
        end else if (c[7:6] == 2'b11 || !c[7]) begin
            // a lead or ASCII byte closes the held sequence
            if (held_len > 0) begin
                w = utf8_lead_len(held_seq[0]);
                if (w == 0 || w == held_len)
                    for (int i = 0; i < held_len; i++) chars.push_back(held_seq[i]);
            end
            held_len = 0;
            if (!c[7]) begin
                case (c)
                    ChAmp:             ent = "&amp;";
                    ChLt:              ent = "&lt;";
                    ChGt:              ent = "&gt;";
                    ChQuot:            ent = "&quot;";
                    ChApos:            ent = "&apos;";
                    ChTab, ChLf, ChCr: chars.push_back(ChSpace);
                    default:           if (c >= ChSpace) chars.push_back(c);
                endcase
                for (int k = 0; k < ent.len(); k++) chars.push_back(ent[k]);
            end else begin
                held_seq[0] = c;
                held_len = 1;
            end
        end else if (held_len > 0) begin
            // continuation: too wide drops the whole sequence
            if (held_len >= SEQ_SLOTS - 1) begin
                held_len = 0;
            end else begin
                held_seq[held_len] = c;
                held_len++;
            end
        end
        for (int i = 0; i < chars.size(); i++)
            expected_chars.push_back(t_out_beat'{val: chars[i], last: (i == chars.size() - 1)});
    endtask

    task automatic add_byte(input logic [7:0] data);
        text_items.push_back(t_text_item'{kind: K_DATA, data: data, drain: drain_next});
        drain_next = 1'b0;
    endtask

    task automatic add_end();
        text_items.push_back(t_text_item'{kind: K_END, data: 8'($urandom_range(0, 255)),
                                          drain: drain_next});
        drain_next = 1'b0;
    endtask

    function automatic logic [7:0] lead_of(input int w);
        case (w)
            2:       return 8'hC0 | 8'($urandom_range(0, 31));
            3:       return 8'hE0 | 8'($urandom_range(0, 15));
            4:       return 8'hF0 | 8'($urandom_range(0, 7));
            5:       return 8'hF8 | 8'($urandom_range(0, 3));
            default: return 8'hFC | 8'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic add_seq(input logic [7:0] lead, input int n_cont);
        add_byte(lead);
        for (int k = 0; k < n_cont; k++) add_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    // Mostly short gaps, a few long ones, none during quiet windows
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((tb_cycle / 500) % 3 == 1) return 0;
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sender: one transfer per item, held until accepted
    always @(negedge i_clk) begin
        tb_cycle++;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_taken) begin
            // hold the current transfer
        end else if (send_gap > 0) begin
            send_gap--;
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom_range(0, 255));
            i_s_tuser  <= 1'($urandom_range(0, 1));
        end else if (text_items.size() > 0 &&
                     !(text_items[0].drain && expected_chars.size() != 0)) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= text_items[0].data;
            i_s_tuser  <= text_items[0].kind;
            void'(text_items.pop_front());
            send_gap = draw_gap();
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            sink_stall = draw_gap();
        end
    end

    // Monitor: check output transfers, then predict for accepted inputs
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected output: expected none, actual %02h last %0b",
                             $time, o_m_tdata, o_m_tlast);
                    mismatch_cnt++;
                end else begin
                    exp_beat = expected_chars.pop_front();
                    if (o_m_tdata !== exp_beat.val || o_m_tlast !== exp_beat.last) begin
                        $display("%0t: output mismatch: expected %02h last %0b, %s %02h last %0b",
                                 $time, exp_beat.val, exp_beat.last, "actual",
                                 o_m_tdata, o_m_tlast);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                in_taken = 1'b1;
                predict_escaped(t_item_kind'(i_s_tuser), i_s_tdata);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [7:0] specials[5];
        int n_tok;
        int r;
        int w;
        int nc;
        int directed_cnt;
        int next_drain;
        specials = '{ChAmp, ChLt, ChGt, ChQuot, ChApos};

        // entities, control bytes and extremes
        add_byte(ChAmp);
        add_byte(ChLt);
        add_byte(ChGt);
        add_byte(ChQuot);
        add_byte(ChApos);
        add_byte(ChTab);
        add_byte(ChLf);
        add_byte(ChCr);
        add_byte(ChNul);
        add_byte(8'h1F);
        add_byte(8'h7F);
        add_byte(8'h80);             // stray continuation
        add_seq(8'hC3, 1);           // well-formed two-byte sequence
        add_seq(8'hE2, 1);           // short three-byte sequence, dropped
        add_byte(ChAmp);
        add_seq(8'hFC, 1);           // unchecked lead
        add_seq(8'hFF, 0);           // lone 0xFF, emitted at next lead
        add_byte(8'hC0);
        add_end();                   // end flushes the held 0xC0 unchecked
        add_end();                   // end with nothing held
        add_seq(8'hF0, 1);           // truncated sequence flushed by end
        add_end();
        directed_cnt = text_items.size();

        // random part opens with wide, too-wide and longest-flush sequences
        add_seq(lead_of(4), 3);
        add_seq(lead_of(5), 4);
        add_seq(lead_of(2), SEQ_SLOTS);
        add_byte(8'h61);
        add_seq(lead_of(0), SEQ_SLOTS - 2);
        add_end();

        next_drain = 150;
        while (text_items.size() - directed_cnt < RANDOM_ITEMS) begin
            n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 12);
            for (int t = 0; t < n_tok; t++) begin
                if (text_items.size() - directed_cnt >= next_drain) begin
                    drain_next = 1'b1;
                    next_drain += 150;
                end
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    add_byte(8'($urandom_range(8'h20, 8'h7E)));
                end else if (r < 40) begin
                    add_byte(specials[$urandom_range(0, 4)]);
                end else if (r < 46) begin
                    add_byte(8'($urandom_range(0, 31)));
                end else if (r < 72) begin
                    w = $urandom_range(2, 5);
                    add_seq(lead_of(w), w - 1);
                end else if (r < 77) begin
                    add_seq(lead_of(0), $urandom_range(0, 6));
                end else if (r < 85) begin
                    // wrong number of continuations
                    w = $urandom_range(2, 5);
                    nc = $urandom_range(0, 6);
                    if (nc == w - 1) nc++;
                    add_seq(lead_of(w), nc);
                end else if (r < 89) begin
                    add_byte(8'h80 | 8'($urandom_range(0, 63)));
                end else if (r < 91) begin
                    add_seq(lead_of($urandom_range(2, 5)),
                            $urandom_range(SEQ_SLOTS - 3, SEQ_SLOTS + 2));
                end else begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            end
            add_end();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_items.size() != 0 || i_s_tvalid) @(negedge i_clk);
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);

        if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #18_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/xes_pkg.sv
rtl/core/xes_ctrl.sv
rtl/core/xes_datapath.sv
rtl/core/xml_escape_utf8_sanitizer_top.sv
rtl/core/xes_checker.sv
dv/xml_escape_utf8_sanitizer_top_test.sv
